FILE: design/tgs_pkg.sv
// ============================================================================
// tgs_pkg: shared types and constants of the twist gesture scroll block
// Holds the payload structs, the configuration record and the fixed-point
// widths used by the register file, the multiplier and the sequencer.
// ============================================================================
package tgs_pkg;

    // Fixed-point layout.
    localparam int FRAC_BITS  = 8;   // fraction bits of the mean and of z
    localparam int COEF_BITS  = 8;   // Q0.8 coefficients: alpha and scale
    localparam int MEAN_W     = 25;  // saturated mean width
    localparam int DELTA_W    = 16;  // sample component width
    localparam int OP_W       = 26;  // shared multiplier operand width
    localparam int PROD_W     = 2 * OP_W;
    localparam int Z_W        = 42;  // cross product width
    localparam int SC_W       = 25;  // scale * delta width
    localparam int SPEED_W    = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register reset values.
    localparam logic [7:0]  RST_FILTER_ALPHA    = 8'd31;
    localparam logic [31:0] RST_MIN_SPEED_SQ    = 32'd4;
    localparam logic [31:0] RST_MAX_SPEED_SQ    = 32'd10000;
    localparam logic [39:0] RST_TWIST_LEVEL     = 40'd1536;
    localparam logic [15:0] RST_DECAY_TICKS     = 16'd40;
    localparam logic [7:0]  RST_SCROLL_GAIN     = 8'd31;
    localparam logic [6:0]  RST_SCROLL_LIMIT    = 7'd6;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } in_t;

    typedef struct packed {
        logic                      report_kind;
        logic signed [DELTA_W-1:0] move_x;
        logic signed [DELTA_W-1:0] move_y;
        logic signed [7:0]         scroll_steps;
    } out_t;

    typedef struct packed {
        logic        twist_enable;
        logic [7:0]  filter_alpha;
        logic [31:0] min_speed_sq;
        logic [31:0] max_speed_sq;
        logic [39:0] twist_level;
        logic [15:0] decay_ticks;
        logic [7:0]  scroll_gain;
        logic [6:0]  scroll_limit;
    } cfg_t;

    localparam logic REPORT_POINTER = 1'b0;
    localparam logic REPORT_SCROLL  = 1'b1;

endpackage

FILE: design/twist_gesture_scroll_top.sv
// ============================================================================
// twist_gesture_scroll_top: trackball twist-to-scroll gesture block
// Turns motion samples into either pointer moves or vertical scroll steps,
// depending on the twist mode and the detected rotational motion.
// ============================================================================
//
//   Channel  Direction  Handshake                Carries
//   -------  ---------  -----------------------  ------------------------------
//   s_       in         s_valid / s_ready        one motion sample (dx, dy)
//   m_       out        m_valid / m_ready        one pointer or scroll report
//   APB      in/out     psel/penable, pready=1   configuration, 8-byte stride
//
// A sample transfer is followed by the sequencing steps on the single shared
// 26 x 26 multiplier and the load of the output register; s_ready stays low
// until that load, so the block takes no new sample while one is in flight.
// The output register lets a new sample start while the last report waits;
// that sample then holds in its final cycle until the register frees up.
// Reset is synchronous and active low; it clears the mean vector, the decay
// counter and all handshake state, and loads the register defaults.
// ============================================================================
module twist_gesture_scroll_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tgs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tgs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tgs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // Sample channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tgs_pkg::in_t                   s_data,
    // Report channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output tgs_pkg::out_t                  m_data
);
    import tgs_pkg::*;

    cfg_t                     cfg;
    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0] prod;

    // The register file holds every tunable of the gesture detector. The user
    // must write it only with no sample in flight; the block does not enforce it.
    tgs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // All products of a sample (speed squares, filter taps, the cross product
    // and its scaling) go through this one registered multiplier in turn.
    tgs_mac u_mac (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // The core sequences the multiplier, accumulates the partial results,
    // updates the mean and decay state and drives the report transfer.
    tgs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod)
    );

endmodule

FILE: design/tgs_regs.sv
// ============================================================================
// tgs_regs: configuration register file
// APB-style slave with zero wait states. Register i sits at byte address 8*i.
// ============================================================================
module tgs_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tgs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tgs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tgs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output tgs_pkg::cfg_t                  cfg
);
    import tgs_pkg::*;

    typedef enum logic [2:0] {
        REG_TWIST_ENABLE,
        REG_FILTER_ALPHA,
        REG_MIN_SPEED_SQ,
        REG_MAX_SPEED_SQ,
        REG_TWIST_LEVEL,
        REG_DECAY_TICKS,
        REG_SCROLL_GAIN,
        REG_SCROLL_LIMIT
    } reg_idx_t;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.twist_enable    <= 1'b0;
            cfg_reg.filter_alpha    <= RST_FILTER_ALPHA;
            cfg_reg.min_speed_sq    <= RST_MIN_SPEED_SQ;
            cfg_reg.max_speed_sq    <= RST_MAX_SPEED_SQ;
            cfg_reg.twist_level     <= RST_TWIST_LEVEL;
            cfg_reg.decay_ticks     <= RST_DECAY_TICKS;
            cfg_reg.scroll_gain     <= RST_SCROLL_GAIN;
            cfg_reg.scroll_limit    <= RST_SCROLL_LIMIT;
        end else if (wr_en) begin
            case (idx)
                REG_TWIST_ENABLE:    cfg_reg.twist_enable    <= pwdata[0];
                REG_FILTER_ALPHA:    cfg_reg.filter_alpha    <= pwdata[7:0];
                REG_MIN_SPEED_SQ:    cfg_reg.min_speed_sq    <= pwdata[31:0];
                REG_MAX_SPEED_SQ:    cfg_reg.max_speed_sq    <= pwdata[31:0];
                REG_TWIST_LEVEL:     cfg_reg.twist_level     <= pwdata[39:0];
                REG_DECAY_TICKS:     cfg_reg.decay_ticks     <= pwdata[15:0];
                REG_SCROLL_GAIN:     cfg_reg.scroll_gain     <= pwdata[7:0];
                REG_SCROLL_LIMIT:    cfg_reg.scroll_limit    <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TWIST_ENABLE:    prdata = CFG_DATA_W'(cfg_reg.twist_enable);
            REG_FILTER_ALPHA:    prdata = CFG_DATA_W'(cfg_reg.filter_alpha);
            REG_MIN_SPEED_SQ:    prdata = CFG_DATA_W'(cfg_reg.min_speed_sq);
            REG_MAX_SPEED_SQ:    prdata = CFG_DATA_W'(cfg_reg.max_speed_sq);
            REG_TWIST_LEVEL:     prdata = CFG_DATA_W'(cfg_reg.twist_level);
            REG_DECAY_TICKS:     prdata = CFG_DATA_W'(cfg_reg.decay_ticks);
            REG_SCROLL_GAIN:     prdata = CFG_DATA_W'(cfg_reg.scroll_gain);
            REG_SCROLL_LIMIT:    prdata = CFG_DATA_W'(cfg_reg.scroll_limit);
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: design/tgs_mac.sv
// ============================================================================
// tgs_mac: shared signed multiplier
// One registered signed multiply per cycle; operands are chosen by the
// sequencer, and the product is available in the cycle after issue.
// ============================================================================
module tgs_mac (
    input  logic                                  aclk,
    input  logic signed [tgs_pkg::OP_W-1:0]       op_a,
    input  logic signed [tgs_pkg::OP_W-1:0]       op_b,
    output logic signed [tgs_pkg::PROD_W-1:0]     prod
);
    import tgs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/tgs_core.sv
// ============================================================================
// tgs_core: sample sequencer, accumulator and gesture state
// Steps one sample through the shared multiplier, keeps the mean vector and
// the decay counter, and holds the result in an output register.
// ============================================================================
module tgs_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tgs_pkg::cfg_t                     cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tgs_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tgs_pkg::out_t                     m_data,
    output logic signed [tgs_pkg::OP_W-1:0]   op_a,
    output logic signed [tgs_pkg::OP_W-1:0]   op_b,
    input  logic signed [tgs_pkg::PROD_W-1:0] prod
);
    import tgs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

    // Named after the multiplication issued in that step; the last two issue none.
    typedef enum logic [3:0] {
        STEP_SQ_X, STEP_SQ_Y, STEP_MX_OLD, STEP_MX_NEW, STEP_MY_OLD, STEP_MY_NEW,
        STEP_SC_X, STEP_SC_Y, STEP_Z_A, STEP_Z_B, STEP_ZS_A, STEP_ZS_B,
        STEP_ACC_ZS, STEP_ROUND
    } step_t;

    localparam int ZS_SHIFT = FRAC_BITS + COEF_BITS;
    localparam logic signed [PROD_W-1:0] MEAN_HI =
        {{(PROD_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] MEAN_LO =
        {{(PROD_W-MEAN_W+1){1'b1}}, {(MEAN_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] MEAN_HALF    = PROD_W'(64'd1 << (COEF_BITS-1));
    localparam logic signed [PROD_W-1:0] MEAN_HALF_M1 = PROD_W'((64'd1 << (COEF_BITS-1)) - 1);
    localparam logic signed [PROD_W-1:0] ZS_HALF      = PROD_W'(64'd1 << (ZS_SHIFT-1));
    localparam logic signed [PROD_W-1:0] ZS_HALF_M1   = PROD_W'((64'd1 << (ZS_SHIFT-1)) - 1);
    localparam logic [COEF_BITS:0]       COEF_ONE     = (COEF_BITS+1)'(1 << COEF_BITS);

    state_t                    state_reg;
    step_t                     step_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [MEAN_W-1:0]  mx_reg, my_reg;
    logic signed [SC_W-1:0]    sdx_reg, sdy_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      like_reg;
    logic [15:0]               decay_reg;
    logic                      m_valid_reg;
    out_t                      out_reg;

    // Round half away from zero by the coefficient scale, then saturate.
    function automatic logic signed [MEAN_W-1:0] mean_round(
        input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + (v[PROD_W-1] ? MEAN_HALF_M1 : MEAN_HALF);
        t = t >>> COEF_BITS;
        if (t > MEAN_HI) begin
            t = MEAN_HI;
        end else if (t < MEAN_LO) begin
            t = MEAN_LO;
        end
        return t[MEAN_W-1:0];
    endfunction

    function automatic logic signed [OP_W-1:0] ext_delta(input logic signed [DELTA_W-1:0] v);
        return {{(OP_W-DELTA_W){v[DELTA_W-1]}}, v};
    endfunction

    function automatic logic signed [OP_W-1:0] ext_mean(input logic signed [MEAN_W-1:0] v);
        return {{(OP_W-MEAN_W){v[MEAN_W-1]}}, v};
    endfunction

    function automatic logic signed [OP_W-1:0] ext_sc(input logic signed [SC_W-1:0] v);
        return {{(OP_W-SC_W){v[SC_W-1]}}, v};
    endfunction

    function automatic logic signed [OP_W-1:0] ext_coef(input logic [COEF_BITS:0] v);
        return {{(OP_W-COEF_BITS-1){1'b0}}, v};
    endfunction

    logic [COEF_BITS:0] one_m_alpha;
    assign one_m_alpha = COEF_ONE - {1'b0, cfg.filter_alpha};

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_SQ_X:   begin op_a = ext_delta(dx_reg); op_b = ext_delta(dx_reg); end
                STEP_SQ_Y:   begin op_a = ext_delta(dy_reg); op_b = ext_delta(dy_reg); end
                STEP_MX_OLD: begin op_a = ext_coef(one_m_alpha); op_b = ext_mean(mx_reg); end
                STEP_MX_NEW: begin
                    op_a = ext_coef({1'b0, cfg.filter_alpha});
                    op_b = ext_delta(dx_reg);
                end
                STEP_MY_OLD: begin op_a = ext_coef(one_m_alpha); op_b = ext_mean(my_reg); end
                STEP_MY_NEW: begin
                    op_a = ext_coef({1'b0, cfg.filter_alpha});
                    op_b = ext_delta(dy_reg);
                end
                STEP_SC_X:   begin
                    op_a = ext_coef({1'b0, cfg.scroll_gain});
                    op_b = ext_delta(dx_reg);
                end
                STEP_SC_Y:   begin
                    op_a = ext_coef({1'b0, cfg.scroll_gain});
                    op_b = ext_delta(dy_reg);
                end
                STEP_Z_A:    begin op_a = ext_delta(dx_reg); op_b = ext_mean(my_reg); end
                STEP_Z_B:    begin op_a = ext_delta(dy_reg); op_b = ext_mean(mx_reg); end
                STEP_ZS_A:   begin op_a = ext_sc(sdx_reg);   op_b = ext_mean(my_reg); end
                STEP_ZS_B:   begin op_a = ext_sc(sdy_reg);   op_b = ext_mean(mx_reg); end
                default: ;
            endcase
        end
    end

    // Twist test on the finished cross product.
    logic [Z_W-1:0] z_mag;
    logic           like_now;
    assign z_mag    = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);
    assign like_now = (speed_reg >= cfg.min_speed_sq) && (speed_reg <= cfg.max_speed_sq) &&
                      (z_mag >= Z_W'(cfg.twist_level));

    // Result formation from the rounded scaled cross product.
    logic signed [PROD_W-1:0] steps_full, lim_pos, lim_neg;
    logic signed [7:0]        steps;
    logic                     active, do_scroll, do_move, reload, out_free;
    logic                     m_valid_next;
    logic [15:0]              decay_next;
    out_t                     result;

    always_comb begin
        steps_full = acc_reg >>> ZS_SHIFT;
        lim_pos    = $signed({{(PROD_W-7){1'b0}}, cfg.scroll_limit});
        lim_neg    = -lim_pos;
        if (steps_full > lim_pos) begin
            steps = lim_pos[7:0];
        end else if (steps_full < lim_neg) begin
            steps = lim_neg[7:0];
        end else begin
            steps = steps_full[7:0];
        end

        active    = like_reg || (decay_reg != 16'd0);
        do_scroll = cfg.twist_enable && active && (steps != 8'sd0);
        do_move   = !cfg.twist_enable && ((dx_reg != '0) || (dy_reg != '0));
        reload    = cfg.twist_enable && like_reg;

        if (reload) begin
            decay_next = (cfg.decay_ticks != 16'd0) ? cfg.decay_ticks - 16'd1 : 16'd0;
        end else if (decay_reg != 16'd0) begin
            decay_next = decay_reg - 16'd1;
        end else begin
            decay_next = decay_reg;
        end

        result.report_kind  = do_scroll ? REPORT_SCROLL : REPORT_POINTER;
        result.move_x       = do_scroll ? '0 : dx_reg;
        result.move_y       = do_scroll ? '0 : dy_reg;
        result.scroll_steps = do_scroll ? steps : 8'sd0;

        out_free = !m_valid_reg || m_ready;

        // A waiting report leaves on m_ready; a finished sample refills the
        // register in the same cycle.
        m_valid_next = m_valid_reg && !m_ready;
        if ((state_reg == ST_EMIT) && out_free) begin
            m_valid_next = do_scroll || do_move;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_SQ_X;
            mx_reg      <= '0;
            my_reg      <= '0;
            decay_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dx_reg    <= s_data.delta_x;
                        dy_reg    <= s_data.delta_y;
                        step_reg  <= STEP_SQ_X;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (step_reg)
                        STEP_SQ_Y:   acc_reg <= prod;
                        STEP_MX_OLD: acc_reg <= acc_reg + prod;
                        STEP_MX_NEW: begin
                            speed_reg <= acc_reg[SPEED_W-1:0];
                            acc_reg   <= prod;
                        end
                        STEP_MY_OLD: acc_reg <= acc_reg + (prod <<< FRAC_BITS);
                        STEP_MY_NEW: begin
                            mx_reg  <= mean_round(acc_reg);
                            acc_reg <= prod;
                        end
                        STEP_SC_X:   acc_reg <= acc_reg + (prod <<< FRAC_BITS);
                        STEP_SC_Y: begin
                            my_reg  <= mean_round(acc_reg);
                            sdx_reg <= prod[SC_W-1:0];
                        end
                        STEP_Z_A:    sdy_reg <= prod[SC_W-1:0];
                        STEP_Z_B:    acc_reg <= prod;
                        STEP_ZS_A:   acc_reg <= acc_reg - prod;
                        STEP_ZS_B: begin
                            z_reg   <= acc_reg[Z_W-1:0];
                            acc_reg <= prod;
                        end
                        STEP_ACC_ZS: acc_reg <= acc_reg - prod;
                        STEP_ROUND: begin
                            acc_reg  <= acc_reg + (acc_reg[PROD_W-1] ? ZS_HALF_M1 : ZS_HALF);
                            like_reg <= like_now;
                        end
                        default: ;
                    endcase
                    if (step_reg == STEP_ROUND) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        step_reg <= step_t'(step_reg + 4'd1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_reg     <= result;
                        decay_reg   <= decay_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A scroll transfer always carries nonzero steps within the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.report_kind == REPORT_SCROLL) |->
            (m_data.scroll_steps != 8'sd0) &&
            ($signed(m_data.scroll_steps) <= $signed({1'b0, cfg.scroll_limit})) &&
            ($signed(m_data.scroll_steps) >= -$signed({1'b0, cfg.scroll_limit})))
        else $error("scroll steps zero or beyond limit");

    // A pointer transfer never carries a zero move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.report_kind == REPORT_POINTER) |->
            (m_data.move_x != '0 || m_data.move_y != '0))
        else $error("zero pointer move delivered");

    // An accepted sample starts the sequence at its first step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == STEP_SQ_X))
        else $error("sequence did not start at first step");

    // The sequencer leaves the run state only after the rounding step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg != STEP_ROUND) |=> (state_reg == ST_RUN))
        else $error("sequence left run state early");

endmodule

FILE: bench/twist_gesture_scroll_top_tb.sv
// ============================================================================
// twist_gesture_scroll_top_tb: self-checking bench for the twist scroll block
// Sends trackball motion samples through the sample channel under several
// register settings. It predicts every pointer or scroll report with its own
// fixed-point model of the gesture filter and checks the report channel in
// order. All registers are written, and then read back, over the APB port.
// ============================================================================
module twist_gesture_scroll_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tgs_pkg::*;

    // Register map: register i sits at byte address 8*i because of the 40-bit
    // threshold register.
    localparam int REG_TWIST_ENABLE    = 0;
    localparam int REG_FILTER_ALPHA    = 1;
    localparam int REG_MIN_SPEED_SQ    = 2;
    localparam int REG_MAX_SPEED_SQ    = 3;
    localparam int REG_TWIST_LEVEL     = 4;
    localparam int REG_DECAY_TICKS     = 5;
    localparam int REG_SCROLL_GAIN     = 6;
    localparam int REG_SCROLL_LIMIT    = 7;

    localparam longint MEAN_HI = 64'sd16777215;
    localparam longint MEAN_LO = -64'sd16777216;

    // A sample that yields no report may still be in flight when the last
    // report leaves, so let this many cycles pass before touching the
    // registers.
    localparam int DRAIN_CYCLES = 48;
    // The slowest correct run stays well under this limit.
    localparam int LIMIT_CYCLES = 600000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;

    twist_gesture_scroll_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Samples waiting to be driven, and reports the gesture model expects,
    // oldest first.
    in_t  pending_samples[$];
    out_t expected_reports[$];

    // Model state: a private copy of the registers and of the filter state.
    cfg_t   shadow_cfg;
    longint mean_x = 0;
    longint mean_y = 0;
    int     decay_left = 0;

    // Traffic shaping, set by the sequence and read by the driving processes.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit sample_taken = 1'b0;
    int gesture_dir = 0;

    // Bookkeeping.
    int cycle_count = 0;
    int error_count = 0;
    int queued_total = 0;
    int accepted_samples = 0;
    int pointer_reports = 0;
    int scroll_reports = 0;
    int reg_writes = 0;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Every failure goes through here: one line each, and it is counted.
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Gesture model.
    // ------------------------------------------------------------------------

    // Divides by 2^sh and rounds half away from zero.
    function automatic longint round_half_away(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // One step of the low-pass filter on one axis; the sample is lifted to the
    // mean's 8 fraction bits and the result is saturated to 25 signed bits.
    function automatic longint smooth_axis(longint m, longint d);
        longint a;
        longint acc;
        longint r;
        a = shadow_cfg.filter_alpha;
        acc = (256 - a) * m + a * (d * 256);
        r = round_half_away(acc, 8);
        if (r > MEAN_HI) r = MEAN_HI;
        if (r < MEAN_LO) r = MEAN_LO;
        return r;
    endfunction

    // Runs one accepted sample through the model and queues the report that
    // it causes, if any.
    function automatic void predict_report(in_t smp);
        longint dx;
        longint dy;
        longint speed_sq;
        longint z;
        longint zmag;
        longint steps;
        longint lim;
        bit     like;
        bit     reload;
        out_t   want;
        dx = longint'($signed(smp.delta_x));
        dy = longint'($signed(smp.delta_y));
        speed_sq = dx * dx + dy * dy;
        reload = 1'b0;
        want = '0;

        // The mean is updated first; the cross product uses the new mean.
        mean_x = smooth_axis(mean_x, dx);
        mean_y = smooth_axis(mean_y, dy);
        z = dx * mean_y - dy * mean_x;
        zmag = (z < 0) ? -z : z;

        like = (speed_sq >= shadow_cfg.min_speed_sq) &&
               (speed_sq <= shadow_cfg.max_speed_sq) &&
               (zmag >= shadow_cfg.twist_level);

        if (shadow_cfg.twist_enable && (like || decay_left > 0)) begin
            reload = like;
            steps = round_half_away(z * longint'(shadow_cfg.scroll_gain), FRAC_BITS + 8);
            lim = shadow_cfg.scroll_limit;
            if (steps > lim) steps = lim;
            if (steps < -lim) steps = -lim;
            // A scroll of zero steps is not reported.
            if (steps != 0) begin
                want.report_kind = REPORT_SCROLL;
                want.scroll_steps = 8'(steps);
                expected_reports.push_back(want);
            end
        end else if (!shadow_cfg.twist_enable && (dx != 0 || dy != 0)) begin
            want.report_kind = REPORT_POINTER;
            want.move_x = smp.delta_x;
            want.move_y = smp.delta_y;
            expected_reports.push_back(want);
        end

        // The decay counter reloads on a twist in twist mode and otherwise
        // counts down to zero, in pointer mode too.
        if (reload) begin
            decay_left = (shadow_cfg.decay_ticks > 0) ? shadow_cfg.decay_ticks - 1 : 0;
        end else if (decay_left > 0) begin
            decay_left--;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver. It changes the channel only at the falling edge, and it
    // only moves on once the current sample's transfer was seen at the rising
    // edge. An idle draw keeps valid low for that cycle.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sample_taken) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data <= pending_samples.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        sample_taken = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Report receiver. A long hold keeps ready low for a counted stretch so
    // that the block fills up and stalls the sample channel; otherwise ready
    // drops at random at the current idle rate.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge: a sample transfer
    // feeds the model, and a report transfer is checked field by field against
    // the oldest expected report.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_report(s_data);
                sample_taken = 1'b1;
                accepted_samples++;
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected report %p", m_data));
                end else begin
                    want = expected_reports.pop_front();
                    if (m_data.report_kind !== want.report_kind)
                        report_mismatch($sformatf("report_kind %b, expected %b",
                                                  m_data.report_kind, want.report_kind));
                    if (m_data.move_x !== want.move_x)
                        report_mismatch($sformatf("move_x %0d, expected %0d",
                                                  m_data.move_x, want.move_x));
                    if (m_data.move_y !== want.move_y)
                        report_mismatch($sformatf("move_y %0d, expected %0d",
                                                  m_data.move_y, want.move_y));
                    if (m_data.scroll_steps !== want.scroll_steps)
                        report_mismatch($sformatf("scroll_steps %0d, expected %0d",
                                                  m_data.scroll_steps, want.scroll_steps));
                    if (want.report_kind == REPORT_SCROLL) scroll_reports++;
                    else pointer_reports++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access.
    // ------------------------------------------------------------------------

    // Writes one register (setup cycle, access cycle) and reads it straight
    // back; the read data is taken at the edge that ends the access cycle.
    task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 8);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        if (rd !== value)
            report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, rd, value));
    endtask

    task automatic apply_cfg(cfg_t setting);
        write_reg(REG_TWIST_ENABLE, CFG_DATA_W'(setting.twist_enable));
        write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(setting.filter_alpha));
        write_reg(REG_MIN_SPEED_SQ, CFG_DATA_W'(setting.min_speed_sq));
        write_reg(REG_MAX_SPEED_SQ, CFG_DATA_W'(setting.max_speed_sq));
        write_reg(REG_TWIST_LEVEL, CFG_DATA_W'(setting.twist_level));
        write_reg(REG_DECAY_TICKS, CFG_DATA_W'(setting.decay_ticks));
        write_reg(REG_SCROLL_GAIN, CFG_DATA_W'(setting.scroll_gain));
        write_reg(REG_SCROLL_LIMIT, CFG_DATA_W'(setting.scroll_limit));
        shadow_cfg = setting;
    endtask

    function automatic cfg_t reset_cfg();
        cfg_t c;
        c.twist_enable = 1'b0;
        c.filter_alpha = RST_FILTER_ALPHA;
        c.min_speed_sq = RST_MIN_SPEED_SQ;
        c.max_speed_sq = RST_MAX_SPEED_SQ;
        c.twist_level = RST_TWIST_LEVEL;
        c.decay_ticks = RST_DECAY_TICKS;
        c.scroll_gain = RST_SCROLL_GAIN;
        c.scroll_limit = RST_SCROLL_LIMIT;
        return c;
    endfunction

    // A setting in the range where circular motion of small radius is
    // recognized as a twist most of the time.
    function automatic cfg_t usable_cfg();
        cfg_t c;
        c.twist_enable = 1'b1;
        c.filter_alpha = 8'($urandom_range(8, 96));
        c.min_speed_sq = $urandom_range(0, 40);
        c.max_speed_sq = $urandom_range(2000, 40000);
        c.twist_level = 40'($urandom_range(0, 6000));
        c.decay_ticks = 16'($urandom_range(0, 60));
        c.scroll_gain = 8'($urandom_range(1, 255));
        c.scroll_limit = 7'($urandom_range(1, 127));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------

    // cos(2*pi*k/16) scaled by 64.
    function automatic int unit16(int k);
        case (k & 15)
            0:  return 64;
            1:  return 59;
            2:  return 45;
            3:  return 24;
            4:  return 0;
            5:  return -24;
            6:  return -45;
            7:  return -59;
            8:  return -64;
            9:  return -59;
            10: return -45;
            11: return -24;
            12: return 0;
            13: return 24;
            14: return 45;
            default: return 59;
        endcase
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic push_sample(logic [15:0] x, logic [15:0] y);
        in_t smp;
        smp.delta_x = x;
        smp.delta_y = y;
        pending_samples.push_back(smp);
        queued_total++;
    endtask

    // Motion around a circle, as a ball spun about its vertical axis gives.
    // A radius of zero picks one at random, mostly small, sometimes huge.
    // An erratic burst keeps flipping its direction of rotation.
    task automatic gesture_burst(int len, int radius, bit erratic);
        int r;
        int stride;
        int jx;
        int jy;
        r = radius;
        if (r == 0) begin
            r = ($urandom_range(9) == 0) ? $urandom_range(100, 32000) : $urandom_range(2, 90);
        end
        stride = $urandom_range(1, 2);
        if ($urandom_range(1)) stride = -stride;
        for (int k = 0; k < len; k++) begin
            if (erratic && $urandom_range(2) == 0) stride = -stride;
            jx = int'($urandom_range(2)) - 1;
            jy = int'($urandom_range(2)) - 1;
            push_sample(16'(unit16(gesture_dir) * r / 64 + jx),
                        16'(unit16(gesture_dir + 12) * r / 64 + jy));
            gesture_dir = (gesture_dir + stride + 16) % 16;
        end
    endtask

    // Mostly well-formed twist gestures with random size and direction; the
    // rest is broken gestures, full-range noise with the corner values, and
    // runs of zero motion that let the decay counter run out.
    task automatic fill_samples(int count);
        int goal;
        int pick;
        int n;
        goal = queued_total + count;
        while (queued_total < goal) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                gesture_burst($urandom_range(4, 20), 0, 1'b0);
            end else if (pick < 76) begin
                gesture_burst($urandom_range(3, 10), 0, 1'b1);
            end else if (pick < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(3) == 0) push_sample(corner_value(), corner_value());
                    else push_sample(16'($urandom), 16'($urandom));
                end
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) push_sample(16'd0, 16'd0);
            end
        end
    endtask

    // Returns once every queued sample has been transferred and every expected
    // report has come back, plus time for a sample that yields no report.
    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_valid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register setting: an optional long receiver hold right at the start,
    // then half the samples, a pause of the sender until all reports are in,
    // and the other half.
    task automatic run_phase(cfg_t setting, int count, int send_pct, int recv_pct, int hold);
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_left = hold;
        apply_cfg(setting);
        fill_samples(count / 2);
        wait_drained();
        fill_samples(count - count / 2);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        cfg_t c;

        // The registers come out of reset at their defaults, pointer mode.
        shadow_cfg = reset_cfg();
        send_idle_pct = 31;
        recv_idle_pct = 46;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, pointer mode on the reset defaults: the corners of
        // both fields and a zero sample, which is not reported.
        push_sample(16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h7FFF);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'h0001, 16'hFFFF);

        // Directed part, twist mode on the defaults: a clean circle that
        // scrolls, zero motion while the decay counter still runs, samples too
        // fast to count as a twist, then a circle that keeps flipping direction.
        wait_drained();
        c = reset_cfg();
        c.twist_enable = 1'b1;
        apply_cfg(c);
        gesture_dir = 0;
        gesture_burst(10, 40, 1'b0);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h8000, 16'h7FFF);
        gesture_burst(5, 60, 1'b1);

        // Random part. The first two settings idle the sender 31% and the
        // receiver 46% of the time, the next two the other way round, and the
        // rest run with no idling at all.

        // Defaults in twist mode, opening with a long receiver hold.
        c = reset_cfg();
        c.twist_enable = 1'b1;
        run_phase(c, 140, 31, 46, 450);

        // Pointer mode with every register at an extreme; the speed limits are
        // inverted, which matters once twist mode returns with the same mean.
        c.twist_enable = 1'b0;
        c.filter_alpha = 8'd0;
        c.min_speed_sq = 32'h8000_0000;
        c.max_speed_sq = 32'd0;
        c.twist_level = 40'hFF_FFFF_FFFF;
        c.decay_ticks = 16'hFFFF;
        c.scroll_gain = 8'd0;
        c.scroll_limit = 7'd0;
        run_phase(c, 120, 31, 46, 0);

        run_phase(usable_cfg(), 150, 46, 31, 300);

        // Twist mode at the other extremes: every sample counts as a twist and
        // the steps reach the widest clamp.
        c.twist_enable = 1'b1;
        c.filter_alpha = 8'd255;
        c.min_speed_sq = 32'd0;
        c.max_speed_sq = 32'h8000_0000;
        c.twist_level = 40'd0;
        c.decay_ticks = 16'hFFFF;
        c.scroll_gain = 8'd255;
        c.scroll_limit = 7'd127;
        run_phase(c, 130, 46, 31, 0);

        // No decay: only the twist samples themselves scroll.
        c = usable_cfg();
        c.decay_ticks = 16'd0;
        run_phase(c, 140, 0, 0, 0);

        // Minimum speed above the maximum: nothing counts as a twist.
        c = usable_cfg();
        c.min_speed_sq = 32'd5000;
        c.max_speed_sq = 32'd100;
        run_phase(c, 40, 0, 0, 0);

        // A scroll limit of zero never lets a report out.
        c = usable_cfg();
        c.scroll_limit = 7'd0;
        run_phase(c, 30, 0, 0, 0);

        // A decay of one tick, then a plain setting to finish.
        c = usable_cfg();
        c.decay_ticks = 16'd1;
        run_phase(c, 60, 0, 0, 0);
        run_phase(usable_cfg(), 40, 0, 0, 0);

        wait_drained();
        $display("Covered %0d samples under 10 register settings: %0d pointer moves, %0d scrolls.",
                 accepted_samples, pointer_reports, scroll_reports);
        $display("%0d register writes read back; %0d mismatches in %0d cycles.",
                 reg_writes, error_count, cycle_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
